// File: rtl/ksc_pkg.sv
// ----------------------------------------------------------------------------
// ksc_pkg
// Shared types and constants for the keyword substitution cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package ksc_pkg;

    localparam int LETTER_COUNT = 26;
    localparam int LETTER_W     = 5;

    typedef logic [LETTER_W-1:0] letter_t;

    localparam letter_t LAST_LETTER = letter_t'(LETTER_COUNT - 1);

    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;

    // operation selector carried in s_tuser
    localparam logic [1:0] OP_KEY = 2'd0;
    localparam logic [1:0] OP_ENC = 2'd1;
    localparam logic [1:0] OP_DEC = 2'd2;

    // result status carried in m_tuser
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_LOADING    = 2'd1;
    localparam logic [1:0] STATUS_NO_LETTERS = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_FILL
    } state_t;

    // request to the alphabet builder
    typedef struct packed {
        logic    add;
        logic    restart;
        letter_t letter;
    } alpha_cmd_t;

endpackage

`default_nettype wire

// File: rtl/ksc_alphabet.sv
// ----------------------------------------------------------------------------
// ksc_alphabet
// Cipher alphabet store: forward and inverse letter tables, used-letter mask
// and key length, with one shared append-letter unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ksc_alphabet (
    input  logic                aclk,
    input  logic                aresetn,
    input  ksc_pkg::alpha_cmd_t cmd,
    input  ksc_pkg::letter_t    rd_letter,
    output ksc_pkg::letter_t    fwd_map,
    output ksc_pkg::letter_t    inv_map,
    output ksc_pkg::letter_t    key_len
);
    import ksc_pkg::*;

    letter_t                  fwd_reg [LETTER_COUNT];
    letter_t                  inv_reg [LETTER_COUNT];
    logic [LETTER_COUNT-1:0]  used_reg;
    logic [LETTER_COUNT-1:0]  used_next;
    letter_t                  key_len_reg;
    letter_t                  key_len_next;

    logic [LETTER_COUNT-1:0]  used_eff;
    letter_t                  key_len_eff;
    logic                     do_add;

    // a new load starts from an empty alphabet
    always_comb begin
        used_eff     = cmd.restart ? '0 : used_reg;
        key_len_eff  = cmd.restart ? '0 : key_len_reg;
        do_add       = cmd.add && !used_eff[cmd.letter]
                       && (key_len_eff < letter_t'(LETTER_COUNT));
        used_next    = used_eff;
        key_len_next = key_len_eff;
        if (do_add) begin
            used_next[cmd.letter] = 1'b1;
            key_len_next          = key_len_eff + letter_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            key_len_reg <= '0;
        end else begin
            used_reg    <= used_next;
            key_len_reg <= key_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LETTER_COUNT; i++) begin
                fwd_reg[i] <= letter_t'(i);
                inv_reg[i] <= letter_t'(i);
            end
        end else if (do_add) begin
            fwd_reg[key_len_eff] <= cmd.letter;
            inv_reg[cmd.letter]  <= key_len_eff;
        end
    end

    assign fwd_map = fwd_reg[rd_letter];
    assign inv_map = inv_reg[rd_letter];
    assign key_len = key_len_reg;

endmodule

`default_nettype wire

// File: rtl/keyword_substitution_cipher.sv
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// Keyword substitution cipher: builds a 26-letter alphabet from keyword words
// and encrypts or decrypts letters through it, keeping case.
// ----------------------------------------------------------------------------
//  channel | dir | signals                          | word
//  --------+-----+----------------------------------+----------------------------
//  s_      | in  | tvalid tready tdata tuser tlast  | in_byte, op, last
//  m_      | out | tvalid tready tdata tuser        | out_byte, status
//
//  cipher words and non-final keyword words each post one registered result
//  the final keyword word is posted after the shared append unit walks A to Z
//  s_tready is low during that walk and while a result waits on a stalled m_
//  aresetn (synchronous) restores the identity alphabet and ends any load
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_substitution_cipher (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [1:0] s_tuser,   // [1:0] op
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser    // [1:0] status
);
    import ksc_pkg::*;

    state_t     state_reg, state_next;
    letter_t    k_reg, k_next;
    logic       loading_reg, loading_next;
    logic       no_letters_reg, no_letters_next;
    logic [7:0] byte_reg, byte_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg, m_data_next;
    logic [1:0] m_user_reg, m_user_next;

    alpha_cmd_t cmd;
    letter_t    in_idx;
    letter_t    fwd_map, inv_map, key_len, map;
    logic       is_upper, is_lower, is_letter, accept;

    ksc_alphabet u_alphabet (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .rd_letter (in_idx),
        .fwd_map   (fwd_map),
        .inv_map   (inv_map),
        .key_len   (key_len)
    );

    // 'A' and 'a' both have 1 in their low five bits
    always_comb begin
        is_upper  = (s_tdata >= UPPER_A) && (s_tdata <= UPPER_Z);
        is_lower  = (s_tdata >= LOWER_A) && (s_tdata <= LOWER_Z);
        is_letter = is_upper || is_lower;
        in_idx    = is_letter ? (s_tdata[4:0] - letter_t'(1)) : '0;
        map       = (s_tuser == OP_ENC) ? fwd_map : inv_map;
    end

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser == OP_KEY) && s_tlast) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                if (k_reg == LAST_LETTER) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        k_next          = k_reg;
        loading_next    = loading_reg;
        no_letters_next = no_letters_reg;
        byte_next       = byte_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        cmd             = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    byte_next = s_tdata;
                    case (s_tuser)
                        OP_KEY: begin
                            cmd.add     = is_letter;
                            cmd.restart = !loading_reg;
                            cmd.letter  = in_idx;
                            if (s_tlast) begin
                                loading_next = 1'b0;
                                k_next       = '0;
                            end else begin
                                loading_next = 1'b1;
                                m_valid_next = 1'b1;
                                m_data_next  = s_tdata;
                                m_user_next  = STATUS_LOADING;
                            end
                        end
                        OP_ENC, OP_DEC: begin
                            m_valid_next = 1'b1;
                            if (loading_reg) begin
                                m_data_next = s_tdata;
                                m_user_next = STATUS_LOADING;
                            end else begin
                                m_user_next = STATUS_OK;
                                if (is_letter) begin
                                    m_data_next = (is_lower ? LOWER_A : UPPER_A)
                                                  + {3'b000, map};
                                end else begin
                                    m_data_next = s_tdata;
                                end
                            end
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_data_next  = s_tdata;
                            m_user_next  = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                // append each still-unused letter in alphabet order
                cmd.add     = 1'b1;
                cmd.restart = 1'b0;
                cmd.letter  = k_reg;
                k_next      = k_reg + letter_t'(1);
                if (k_reg == '0) begin
                    no_letters_next = (key_len == '0);
                end
                if (k_reg == LAST_LETTER) begin
                    m_valid_next = 1'b1;
                    m_data_next  = byte_reg;
                    m_user_next  = no_letters_reg ? STATUS_NO_LETTERS : STATUS_OK;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            loading_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            loading_reg <= loading_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        no_letters_reg <= no_letters_next;
        byte_reg       <= byte_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    // the output register must be free while the fill walk runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |-> !m_valid_reg)
        else $error("result pending during alphabet fill");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL && k_reg == LAST_LETTER)
            |=> (m_valid_reg && state_reg == ST_IDLE && !loading_reg))
        else $error("fill end did not post the final keyword result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && loading_reg && (s_tuser == OP_ENC || s_tuser == OP_DEC))
            |=> (m_tvalid && m_tuser == STATUS_LOADING && m_tdata == $past(s_tdata)))
        else $error("cipher word during key load not passed through");
`endif

endmodule

`default_nettype wire
